/* rtl/scc_pkg.sv */
package scc_pkg;

    localparam int ID_W     = 8;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] src;
        logic [ID_W-1:0] dst;
    } edge_t;

    typedef struct packed {
        logic full;
        logic overflow;
    } edge_stat_t;

endpackage

/* rtl/scc_edge_if.sv */
interface scc_edge_if;
    logic                       valid;
    logic                       ready;
    logic [scc_pkg::ID_W-1:0]   edge_from;
    logic [scc_pkg::ID_W-1:0]   edge_to;
    logic                       edge_present;
    logic                       last_edge;

    modport source (output valid, edge_from, edge_to, edge_present, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, edge_present, last_edge, output ready);
endinterface

/* rtl/scc_result_if.sv */
interface scc_result_if;
    logic                           valid;
    logic                           ready;
    logic [scc_pkg::COUNT_W-1:0]    component_count;
    logic [scc_pkg::STATUS_W-1:0]   status;

    modport source (output valid, component_count, status, input ready);
    modport sink (input valid, component_count, status, output ready);
endinterface

/* rtl/scc_counter.sv */
// Edge words load at one per cycle while loading; the last word starts the count.
// Count steps: a range check of every edge, a clear of the n visited flags before
// each pass, and per pass a depth-first scan with pushes and pops that reads one
// edge per step from the edge memory.
// Result register decouples the output; new edges load while it waits.
// rst_n clears control state; memories are not cleared.
module scc_counter #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [scc_pkg::COUNT_W-1:0]     cfg_wr_data,
    scc_edge_if.sink                        edge_in,
    scc_result_if.source                    result_out
);

    localparam int VW = $clog2(MAX_VERTICES+1);
    localparam int VI = $clog2(MAX_VERTICES);
    localparam int CW = (VW > scc_pkg::COUNT_W) ? VW : scc_pkg::COUNT_W;
    localparam int EW = $clog2(MAX_EDGES+1);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_VAL_RD   = 4'd1;
    localparam logic [3:0] S_VAL_CHK  = 4'd2;
    localparam logic [3:0] S_CLR      = 4'd3;
    localparam logic [3:0] S_NEXT     = 4'd4;
    localparam logic [3:0] S_FIN_WAIT = 4'd5;
    localparam logic [3:0] S_ROOT_CHK = 4'd6;
    localparam logic [3:0] S_EDGE_RD  = 4'd7;
    localparam logic [3:0] S_EDGE_CHK = 4'd8;
    localparam logic [3:0] S_VIS_CHK  = 4'd9;
    localparam logic [3:0] S_POP_WAIT = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0]                     state_reg, state_next;
    logic                           pass2_reg, pass2_next;
    logic [scc_pkg::COUNT_W-1:0]    vc_reg;
    logic [VW-1:0]                  n_reg, n_next;
    logic [VW-1:0]                  idx_reg, idx_next;
    logic [EW-1:0]                  eidx_reg, eidx_next;
    logic [VI-1:0]                  top_v_reg, top_v_next;
    logic [EW-1:0]                  top_c_reg, top_c_next;
    logic [VW-1:0]                  depth_reg, depth_next;
    logic [VW-1:0]                  ftop_reg, ftop_next;
    logic [VI-1:0]                  root_reg, root_next;
    logic [VW-1:0]                  count_reg, count_next;
    logic [scc_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           out_valid_reg;
    logic [scc_pkg::COUNT_W-1:0]    out_count_reg;
    logic [scc_pkg::STATUS_W-1:0]   out_status_reg;

    logic                   in_fire, out_load;
    logic                   store_wr, store_clear;
    scc_pkg::edge_t         store_wdata, edge_rd;
    logic [EA-1:0]          store_raddr;
    logic [EW-1:0]          loaded;
    scc_pkg::edge_stat_t    store_stat;
    logic [CW-1:0]          n_clamp, src_ext, dst_ext, a_ext, w_ext;
    logic [VI-1:0]          w_v;

    logic                   vis_mem [MAX_VERTICES];
    logic                   vis_rdata, vis_we, vis_wdata;
    logic [VI-1:0]          vis_waddr, vis_raddr;
    logic [VI-1:0]          fin_mem [MAX_VERTICES];
    logic [VI-1:0]          fin_rdata;
    logic                   fin_we;
    logic [VI-1:0]          fin_raddr;
    logic [VI+EW-1:0]       stk_mem [MAX_VERTICES];
    logic [VI+EW-1:0]       stk_rdata, stk_wdata;
    logic                   stk_we;
    logic [VI-1:0]          stk_waddr, stk_raddr;

    assign in_fire       = edge_in.valid && edge_in.ready;
    assign edge_in.ready = (state_reg == S_LOAD);
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || result_out.ready);
    assign store_clear   = out_load;
    assign store_wr      = in_fire && edge_in.edge_present;
    assign store_wdata.src = edge_in.edge_from;
    assign store_wdata.dst = edge_in.edge_to;
    assign store_raddr   = (state_reg == S_VAL_RD) ? eidx_reg[EA-1:0] : top_c_reg[EA-1:0];

    assign n_clamp = (CW'(vc_reg) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vc_reg);
    assign src_ext = CW'(edge_rd.src);
    assign dst_ext = CW'(edge_rd.dst);
    assign a_ext   = pass2_reg ? dst_ext : src_ext;
    assign w_ext   = pass2_reg ? src_ext : dst_ext;
    assign w_v     = w_ext[VI-1:0];

    assign result_out.valid           = out_valid_reg;
    assign result_out.component_count = out_count_reg;
    assign result_out.status          = out_status_reg;

    scc_edge_store #(
        .MAX_EDGES (MAX_EDGES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (store_wr),
        .wr_data (store_wdata),
        .clear   (store_clear),
        .rd_addr (store_raddr),
        .rd_data (edge_rd),
        .loaded  (loaded),
        .stat    (store_stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        pass2_next  = pass2_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        eidx_next   = eidx_reg;
        top_v_next  = top_v_reg;
        top_c_next  = top_c_reg;
        depth_next  = depth_reg;
        ftop_next   = ftop_reg;
        root_next   = root_reg;
        count_next  = count_reg;
        status_next = status_reg;
        vis_we      = 1'b0;
        vis_waddr   = root_reg;
        vis_wdata   = 1'b1;
        vis_raddr   = idx_reg[VI-1:0];
        fin_we      = 1'b0;
        fin_raddr   = ftop_reg[VI-1:0] - VI'(1);
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[VI-1:0] - VI'(1);
        stk_wdata   = {top_v_reg, top_c_reg + EW'(1)};
        stk_raddr   = depth_reg[VI-1:0] - VI'(2);

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire && edge_in.last_edge)
                begin
                    n_next      = n_clamp[VW-1:0];
                    count_next  = '0;
                    eidx_next   = '0;
                    status_next = scc_pkg::STATUS_OK;
                    if (store_stat.overflow || (edge_in.edge_present && store_stat.full))
                    begin
                        status_next = scc_pkg::STATUS_CAPACITY;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_VAL_RD;
                end
            end
            S_VAL_RD:
            begin
                if (eidx_reg == loaded)
                begin
                    idx_next   = '0;
                    ftop_next  = '0;
                    pass2_next = 1'b0;
                    state_next = S_CLR;
                end
                else
                    state_next = S_VAL_CHK;
            end
            S_VAL_CHK:
            begin
                if (src_ext >= CW'(n_reg) || dst_ext >= CW'(n_reg))
                begin
                    status_next = scc_pkg::STATUS_RANGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    eidx_next  = eidx_reg + EW'(1);
                    state_next = S_VAL_RD;
                end
            end
            S_CLR:
            begin
                if (idx_reg == n_reg)
                begin
                    idx_next   = '0;
                    state_next = S_NEXT;
                end
                else
                begin
                    vis_we    = 1'b1;
                    vis_waddr = idx_reg[VI-1:0];
                    vis_wdata = 1'b0;
                    idx_next  = idx_reg + VW'(1);
                end
            end
            S_NEXT:
            begin
                if (!pass2_reg)
                begin
                    if (idx_reg == n_reg)
                    begin
                        pass2_next = 1'b1;
                        idx_next   = '0;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        root_next  = idx_reg[VI-1:0];
                        state_next = S_ROOT_CHK;
                    end
                end
                else if (ftop_reg == '0)
                    state_next = S_DONE;
                else
                    state_next = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                root_next  = fin_rdata;
                vis_raddr  = fin_rdata;
                state_next = S_ROOT_CHK;
            end
            S_ROOT_CHK:
            begin
                if (vis_rdata)
                begin
                    if (pass2_reg)
                        ftop_next = ftop_reg - VW'(1);
                    else
                        idx_next = idx_reg + VW'(1);
                    state_next = S_NEXT;
                end
                else
                begin
                    vis_we     = 1'b1;
                    top_v_next = root_reg;
                    top_c_next = '0;
                    depth_next = VW'(1);
                    if (pass2_reg)
                        count_next = count_reg + VW'(1);
                    state_next = S_EDGE_RD;
                end
            end
            S_EDGE_RD:
            begin
                if (top_c_reg == loaded)
                begin
                    depth_next = depth_reg - VW'(1);
                    if (!pass2_reg)
                    begin
                        fin_we    = 1'b1;
                        ftop_next = ftop_reg + VW'(1);
                    end
                    if (depth_reg == VW'(1))
                    begin
                        if (pass2_reg)
                            ftop_next = ftop_reg - VW'(1);
                        else
                            idx_next = idx_reg + VW'(1);
                        state_next = S_NEXT;
                    end
                    else
                        state_next = S_POP_WAIT;
                end
                else
                    state_next = S_EDGE_CHK;
            end
            S_EDGE_CHK:
            begin
                vis_raddr = w_v;
                if (a_ext == CW'(top_v_reg))
                    state_next = S_VIS_CHK;
                else
                begin
                    top_c_next = top_c_reg + EW'(1);
                    state_next = S_EDGE_RD;
                end
            end
            S_VIS_CHK:
            begin
                if (vis_rdata)
                    top_c_next = top_c_reg + EW'(1);
                else
                begin
                    stk_we     = 1'b1;
                    vis_we     = 1'b1;
                    vis_waddr  = w_v;
                    top_v_next = w_v;
                    top_c_next = '0;
                    depth_next = depth_reg + VW'(1);
                end
                state_next = S_EDGE_RD;
            end
            S_POP_WAIT:
            begin
                top_v_next = stk_rdata[VI+EW-1:EW];
                top_c_next = stk_rdata[EW-1:0];
                state_next = S_EDGE_RD;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_LOAD;
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            pass2_reg     <= 1'b0;
            vc_reg        <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            eidx_reg      <= '0;
            depth_reg     <= '0;
            ftop_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= scc_pkg::STATUS_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pass2_reg  <= pass2_next;
            n_reg      <= n_next;
            idx_reg    <= idx_next;
            eidx_reg   <= eidx_next;
            depth_reg  <= depth_next;
            ftop_reg   <= ftop_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            if (cfg_wr_en)
                vc_reg <= cfg_wr_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        top_v_reg <= top_v_next;
        top_c_reg <= top_c_next;
        root_reg  <= root_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= (status_reg == scc_pkg::STATUS_OK) ?
                              scc_pkg::COUNT_W'(count_reg) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
            vis_mem[vis_waddr] <= vis_wdata;
        vis_rdata <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fin_we)
            fin_mem[ftop_reg[VI-1:0]] <= top_v_reg;
        fin_rdata <= fin_mem[fin_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rdata <= stk_mem[stk_raddr];
    end

endmodule

/* rtl/scc_edge_store.sv */
module scc_edge_store #(
    parameter int MAX_EDGES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  scc_pkg::edge_t                      wr_data,
    input  logic                                clear,
    input  logic [((MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1)-1:0] rd_addr,
    output scc_pkg::edge_t                      rd_data,
    output logic [$clog2(MAX_EDGES+1)-1:0]      loaded,
    output scc_pkg::edge_stat_t                 stat
);

    localparam int EW = $clog2(MAX_EDGES+1);
    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

    scc_pkg::edge_t     mem [MAX_EDGES];
    logic [EW-1:0]      loaded_reg;
    logic               overflow_reg;
    logic               full;

    assign full          = (loaded_reg == EW'(MAX_EDGES));
    assign loaded        = loaded_reg;
    assign stat.full     = full;
    assign stat.overflow = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (clear)
        begin
            loaded_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            if (full)
                overflow_reg <= 1'b1;
            else
                loaded_reg <= loaded_reg + EW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem[loaded_reg[EA-1:0]] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/scc_counter_checker.sv */
module scc_counter_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            in_last,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [scc_pkg::COUNT_W-1:0]     out_count,
    input  logic [scc_pkg::STATUS_W-1:0]    out_status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == scc_pkg::STATUS_OK ||
                       out_status == scc_pkg::STATUS_CAPACITY ||
                       out_status == scc_pkg::STATUS_RANGE))
        else $error("bad status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != scc_pkg::STATUS_OK |-> out_count == '0)
        else $error("error result with nonzero count");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("edge word taken during count");

endmodule

bind scc_counter scc_counter_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (edge_in.valid),
    .in_ready   (edge_in.ready),
    .in_last    (edge_in.last_edge),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .out_count  (result_out.component_count),
    .out_status (result_out.status)
);

/* test/scc_counter_tb.sv */
`timescale 1ns / 100ps

module scc_counter_tb;

    localparam int NV        = 256;
    localparam int NE        = 1024;
    localparam int IDLE_PCT  = 26;
    localparam int STALL_LEN = 3000;
    localparam int WDOG_MAX  = 1000000;

    typedef struct {
        logic [scc_pkg::ID_W-1:0] from_id;
        logic [scc_pkg::ID_W-1:0] to_id;
        logic                     present;
        logic                     last;
    } edge_word_t;

    typedef struct {
        logic [scc_pkg::COUNT_W-1:0]  count;
        logic [scc_pkg::STATUS_W-1:0] status;
    } scc_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [scc_pkg::COUNT_W-1:0] cfg_wr_data;

    scc_edge_if   edge_if();
    scc_result_if res_if();

    scc_counter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .edge_in     (edge_if.sink),
        .result_out  (res_if.source)
    );

    edge_word_t  pending_words[$];
    scc_result_t expected_counts[$];

    // predictor state
    logic [scc_pkg::COUNT_W-1:0] vertex_limit;
    logic [scc_pkg::ID_W-1:0]    graph_src[$];
    logic [scc_pkg::ID_W-1:0]    graph_dst[$];
    logic                        graph_overflow;
    logic                        seen[NV];
    int                          finish_order[NV];
    int                          finish_top;
    int                          walk_vertex[NV];
    int                          walk_cursor[NV];

    int  errors;
    int  cycle_no;
    int  quiet_cycles;
    int  results_seen;
    int  stall_left;
    bit  stall_done;
    int  wdog;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void walk_from(int root, bit rev);
        int  depth;
        int  v;
        int  a;
        int  w;
        int  e;
        bit  pushed;
        seen[root] = 1'b1;
        walk_vertex[0] = root;
        walk_cursor[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            v = walk_vertex[depth-1];
            pushed = 0;
            for (e = walk_cursor[depth-1]; e < graph_src.size(); e++)
            begin
                a = rev ? graph_dst[e] : graph_src[e];
                w = rev ? graph_src[e] : graph_dst[e];
                if (a == v && w < NV && !seen[w])
                begin
                    walk_cursor[depth-1] = e + 1;
                    if (depth < NV)
                    begin
                        seen[w] = 1'b1;
                        walk_vertex[depth] = w;
                        walk_cursor[depth] = 0;
                        depth++;
                        pushed = 1;
                    end
                    break;
                end
            end
            if (!pushed)
            begin
                depth--;
                if (!rev && finish_top < NV)
                begin
                    finish_order[finish_top] = v;
                    finish_top++;
                end
            end
        end
    endfunction

    function automatic scc_result_t count_components();
        scc_result_t r;
        int n;
        int comps;
        int v;
        n = (vertex_limit > NV) ? NV : int'(vertex_limit);
        r.status = scc_pkg::STATUS_OK;
        r.count = '0;
        if (graph_overflow)
            r.status = scc_pkg::STATUS_CAPACITY;
        else
            foreach (graph_src[i])
                if (graph_src[i] >= n || graph_dst[i] >= n)
                    r.status = scc_pkg::STATUS_RANGE;
        if (r.status == scc_pkg::STATUS_OK)
        begin
            foreach (seen[i])
                seen[i] = 1'b0;
            finish_top = 0;
            for (int i = 0; i < n; i++)
                if (!seen[i])
                    walk_from(i, 1'b0);
            foreach (seen[i])
                seen[i] = 1'b0;
            comps = 0;
            while (finish_top > 0)
            begin
                v = finish_order[finish_top-1];
                if (!seen[v])
                begin
                    walk_from(v, 1'b1);
                    comps++;
                end
                finish_top--;
            end
            r.count = comps[scc_pkg::COUNT_W-1:0];
        end
        return r;
    endfunction

    function automatic void absorb_word(edge_word_t w);
        if (w.present)
        begin
            if (graph_src.size() < NE)
            begin
                graph_src = {graph_src, w.from_id};
                graph_dst = {graph_dst, w.to_id};
            end
            else
                graph_overflow = 1'b1;
        end
        if (w.last)
        begin
            expected_counts = {expected_counts, count_components()};
            graph_src.delete();
            graph_dst.delete();
            graph_overflow = 1'b0;
        end
    endfunction

    function automatic bit side_idles();
        return quiet_cycles == 0 && $urandom_range(99) < IDLE_PCT;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        edge_word_t accepted;
        edge_word_t next_word;
        if (!rst_n)
        begin
            edge_if.valid        <= 1'b0;
            edge_if.edge_from    <= '0;
            edge_if.edge_to      <= '0;
            edge_if.edge_present <= 1'b0;
            edge_if.last_edge    <= 1'b0;
        end
        else
        begin
            if (edge_if.valid && edge_if.ready)
            begin
                accepted.from_id = edge_if.edge_from;
                accepted.to_id   = edge_if.edge_to;
                accepted.present = edge_if.edge_present;
                accepted.last    = edge_if.last_edge;
                absorb_word(accepted);
            end
            if (!edge_if.valid || edge_if.ready)
            begin
                if (pending_words.size() > 0 && !side_idles())
                begin
                    next_word = pending_words.pop_front();
                    edge_if.valid        <= 1'b1;
                    edge_if.edge_from    <= next_word.from_id;
                    edge_if.edge_to      <= next_word.to_id;
                    edge_if.edge_present <= next_word.present;
                    edge_if.last_edge    <= next_word.last;
                end
                else
                    edge_if.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        scc_result_t want;
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected result count=%0d status=%0d",
                           res_if.component_count, res_if.status);
                    errors++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (res_if.component_count !== want.count)
                    begin
                        $error("component_count expected %0d actual %0d",
                               want.count, res_if.component_count);
                        errors++;
                    end
                    if (res_if.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d",
                               want.status, res_if.status);
                        errors++;
                    end
                end
                if (results_seen == 5 && !stall_done)
                begin
                    stall_done = 1;
                    stall_left = STALL_LEN;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= !side_idles();
        end
    end

    always @(posedge clk)
    begin
        cycle_no++;
        if (quiet_cycles > 0)
            quiet_cycles--;
        else if (cycle_no == 4000)
            quiet_cycles = 5000;
        if ((edge_if.valid && edge_if.ready) || (res_if.valid && res_if.ready))
            wdog = 0;
        else
            wdog++;
        if (wdog >= WDOG_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void queue_word(logic [scc_pkg::ID_W-1:0] f,
                                       logic [scc_pkg::ID_W-1:0] t,
                                       logic p, logic l);
        edge_word_t w;
        w.from_id = f;
        w.to_id   = t;
        w.present = p;
        w.last    = l;
        pending_words = {pending_words, w};
    endfunction

    // random graph over 0..n-1; bad_id forces one out-of-range endpoint
    function automatic int queue_graph(int n, int edges, bit bad_id);
        int hi;
        int made;
        int bad_at;
        hi = (n > NV) ? NV - 1 : n - 1;
        made = 0;
        bad_at = (bad_id && edges > 0) ? int'($urandom_range(edges - 1)) : -1;
        for (int i = 0; i < edges; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                queue_word(scc_pkg::ID_W'($urandom_range(255)),
                           scc_pkg::ID_W'($urandom_range(255)), 1'b0, 1'b0);
                made++;
            end
            if (i == bad_at)
            begin
                if ($urandom_range(1))
                    queue_word(scc_pkg::ID_W'($urandom_range(255, n)),
                               scc_pkg::ID_W'($urandom_range(hi)), 1'b1,
                               i == edges - 1);
                else
                    queue_word(scc_pkg::ID_W'($urandom_range(hi)),
                               scc_pkg::ID_W'($urandom_range(255, n)), 1'b1,
                               i == edges - 1);
            end
            else
                queue_word(scc_pkg::ID_W'($urandom_range(hi)),
                           scc_pkg::ID_W'($urandom_range(hi)), 1'b1, i == edges - 1);
            made++;
        end
        if (edges == 0 || $urandom_range(4) == 0)
        begin
            queue_word(scc_pkg::ID_W'($urandom_range(255)),
                       scc_pkg::ID_W'($urandom_range(255)), 1'b0, 1'b1);
            made++;
        end
        return made;
    endfunction

    task automatic settle();
        while (pending_words.size() > 0 || edge_if.valid || expected_counts.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_vertices(logic [scc_pkg::COUNT_W-1:0] n);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= n;
        vertex_limit = n;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int words;
        int n;
        int graphs;
        int edges;
        int big_left;
        errors = 0;
        cycle_no = 0;
        quiet_cycles = 0;
        results_seen = 0;
        stall_left = 0;
        stall_done = 0;
        wdog = 0;
        vertex_limit = '0;
        graph_overflow = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty graph with no vertices
        queue_word(8'h00, 8'h00, 1'b0, 1'b1);
        // every vertex alone; register max clamps to 256
        set_vertices(9'h1FF);
        queue_word(8'hFF, 8'h00, 1'b0, 1'b1);
        // extremes of ids, single-edge graph ending on an edge
        set_vertices(9'd256);
        queue_word(8'hFF, 8'h00, 1'b1, 1'b1);
        queue_word(8'h00, 8'hFF, 1'b1, 1'b0);
        queue_word(8'hFF, 8'h00, 1'b1, 1'b0);
        queue_word(8'hAA, 8'h55, 1'b1, 1'b0);
        queue_word(8'h55, 8'hAA, 1'b0, 1'b1);
        // loop 0-1-2 plus tail 3-4; several graphs back to back to fill the block
        set_vertices(9'd5);
        for (int k = 0; k < 4; k++)
        begin
            queue_word(8'd0, 8'd1, 1'b1, 1'b0);
            queue_word(8'd1, 8'd2, 1'b1, 1'b0);
            queue_word(8'd2, 8'd0, 1'b1, 1'b0);
            queue_word(8'd3, 8'd4, 1'b1, 1'b0);
            queue_word(8'd4, 8'd4, 1'b1, 1'b1);
        end
        // id out of range, then overflow beats range
        queue_word(8'd5, 8'd0, 1'b1, 1'b1);
        set_vertices(9'd2);
        for (int k = 0; k <= NE; k++)
            queue_word((k == 0 || k == NE) ? 8'd9 : 8'd0, 8'd1, 1'b1, k == NE);
        queue_word(8'd1, 8'd0, 1'b1, 1'b1);

        words = 0;
        big_left = 2;
        while (words < 700)
        begin
            case ($urandom_range(9))
                0: n = $urandom_range(1);
                1: n = (big_left > 0) ? 256 : $urandom_range(2, 20);
                default: n = $urandom_range(2, 20);
            endcase
            set_vertices(scc_pkg::COUNT_W'(n));
            graphs = (n == 256) ? 1 : $urandom_range(1, 3);
            for (int g = 0; g < graphs; g++)
            begin
                if (n == 256)
                begin
                    big_left--;
                    words += queue_graph(n, 60, 1'b0);
                end
                else if (n == 0)
                    words += queue_graph(1, $urandom_range(2), 1'b1);
                else
                begin
                    edges = $urandom_range((3 * n > 30) ? 30 : 3 * n);
                    words += queue_graph(n, edges, edges > 0 && $urandom_range(9) == 0);
                end
            end
        end
        settle();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/scc_pkg.sv
rtl/scc_edge_if.sv
rtl/scc_result_if.sv
rtl/scc_edge_store.sv
rtl/scc_counter.sv
rtl/scc_counter_checker.sv
test/scc_counter_tb.sv
